@@ rtl/capacitive_touch_drop_detector_core_macros.svh @@
// assertion helpers shared by the touch detector rtl
`ifndef CAPACITIVE_TOUCH_DROP_DETECTOR_CORE_MACROS_SVH
`define CAPACITIVE_TOUCH_DROP_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off while in reset
`define CTDD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("ctdd assertion failed");
// next-cycle implication, held off while in reset
`define CTDD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("ctdd assertion failed");
`else
`define CTDD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CTDD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/ctdd_pkg.sv @@
package ctdd_pkg;

	// default number of sensed channels
	localparam int CHANNELS_DEFAULT = 3;

	// number of per-channel threshold registers
	localparam int THRESHOLD_REGS = 3;

	// reset values of the configuration registers
	localparam logic [7:0] THRESHOLD_RESET = 8'd20;
	localparam logic [7:0] LOCKOUT_RESET   = 8'd100;

	// operation codes carried in tuser
	localparam logic [1:0] FUNC_CAPTURE = 2'd0;
	localparam logic [1:0] FUNC_TICK    = 2'd1;
	localparam logic [1:0] FUNC_CHECK   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD_CH0 = 2'd0;
	localparam logic [1:0] REG_THRESHOLD_CH1 = 2'd1;
	localparam logic [1:0] REG_THRESHOLD_CH2 = 2'd2;
	localparam logic [1:0] REG_LOCKOUT       = 2'd3;

	// configuration seen by the detection engine
	typedef struct packed {
		logic [THRESHOLD_REGS-1:0][7:0] threshold;
		logic [7:0]                     lockout;
	} cfg_t;

	// one item as held in the input register
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] oscillator_count;
		logic [1:0] check_channel;
	} op_t;

	// one result as produced by the engine
	typedef struct packed {
		logic       touched;
		logic [1:0] scan_channel;
	} res_t;

endpackage

@@ rtl/ctdd_cfg_regs.sv @@
module ctdd_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output ctdd_pkg::cfg_t    cfg
);

	logic [7:0] thr0_q;
	logic [7:0] thr1_q;
	logic [7:0] thr2_q;
	logic [7:0] lockout_q;

	// register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr0_q    <= ctdd_pkg::THRESHOLD_RESET;
			thr1_q    <= ctdd_pkg::THRESHOLD_RESET;
			thr2_q    <= ctdd_pkg::THRESHOLD_RESET;
			lockout_q <= ctdd_pkg::LOCKOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ctdd_pkg::REG_THRESHOLD_CH0: thr0_q    <= cfg_data;
				ctdd_pkg::REG_THRESHOLD_CH1: thr1_q    <= cfg_data;
				ctdd_pkg::REG_THRESHOLD_CH2: thr2_q    <= cfg_data;
				ctdd_pkg::REG_LOCKOUT:       lockout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.threshold = {thr2_q, thr1_q, thr0_q};
	assign cfg.lockout   = lockout_q;

endmodule

@@ rtl/ctdd_engine.sv @@
`include "capacitive_touch_drop_detector_core_macros.svh"

module ctdd_engine #(
	parameter int CHANNELS = ctdd_pkg::CHANNELS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ctdd_pkg::op_t     op,
	input  ctdd_pkg::cfg_t    cfg,
	output ctdd_pkg::res_t    res
);

	localparam int SPW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [SPW-1:0]      ptr_q;
	logic [SPW-1:0]      ptr_nxt;
	logic [SPW-1:0]      ptr_after;
	logic [SPW+1:0]      scan_ext;
	logic [CHANNELS-1:0] hits;
	logic                is_capture;
	logic                is_tick;
	logic                is_check;

	assign is_capture = (op.func == ctdd_pkg::FUNC_CAPTURE);
	assign is_tick    = (op.func == ctdd_pkg::FUNC_TICK);
	assign is_check   = (op.func == ctdd_pkg::FUNC_CHECK);

	// round-robin scan pointer
	assign ptr_nxt = (ptr_q == SPW'(CHANNELS - 1)) ? '0 : SPW'(ptr_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (step && is_capture) begin
			ptr_q <= ptr_nxt;
		end
	end

	// per-channel counts, lockout timer and drop compare
	for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
		logic [7:0] cur_q;
		logic [7:0] prev_q;
		logic [7:0] lock_q;
		logic [7:0] thr;
		logic       sel_scan;
		logic       sel_chk;
		logic       drop;

		if (i < ctdd_pkg::THRESHOLD_REGS) begin : g_thr_reg
			assign thr = cfg.threshold[i];
		end else begin : g_thr_def
			assign thr = ctdd_pkg::THRESHOLD_RESET;
		end

		assign sel_scan = (ptr_q == SPW'(i));
		assign sel_chk  = ({30'd0, op.check_channel} == 32'(i));
		// drop exceeds threshold, compared without wrap
		assign drop     = ({1'b0, prev_q} > ({1'b0, cur_q} + {1'b0, thr}));
		assign hits[i]  = is_check && sel_chk && drop && (lock_q == 8'd0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cur_q  <= '0;
				prev_q <= '0;
				lock_q <= '0;
			end else if (step) begin
				if (is_capture && sel_scan) begin
					prev_q <= cur_q;
					cur_q  <= op.oscillator_count;
				end
				if (hits[i]) begin
					lock_q <= cfg.lockout;
				end else if (is_tick && (lock_q != 8'd0)) begin
					lock_q <= lock_q - 8'd1;
				end
			end
		end
	end

	// result of this item
	assign ptr_after        = is_capture ? ptr_nxt : ptr_q;
	assign scan_ext         = {2'b00, ptr_after};
	assign res.touched      = |hits;
	assign res.scan_channel = scan_ext[1:0];

	`CTDD_ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1, ({{(32-SPW){1'b0}}, ptr_q} < 32'(CHANNELS)))
	`CTDD_ASSERT_IMP(a_one_hit, clk, arst_n, 1'b1, $onehot0(hits))
	`CTDD_ASSERT_NXT(a_ptr_hold, clk, arst_n, (!step || !is_capture), $stable(ptr_q))

endmodule

@@ rtl/capacitive_touch_drop_detector_core.sv @@
// Capacitive touch detector for CHANNELS sensed channels. Each input item carries an
// operation in s_tuser: capture stores the oscillator count for the channel being
// scanned and moves the scan round-robin, tick counts every running lockout timer down
// by one, and check reports a new touch on the channel asked for when its count has
// fallen by more than its threshold and its lockout has run out; a touch restarts that
// lockout. Every item gives exactly one result with the touch flag and the channel to
// scan next. One item is taken every clock cycle while s_tready is high; it passes
// the input register, then state update and result register. Not enforced: the user
// must write configuration via cfg_we/cfg_index/cfg_data while no item is in flight.
`include "capacitive_touch_drop_detector_core_macros.svh"

module capacitive_touch_drop_detector_core #(
	parameter int CHANNELS = ctdd_pkg::CHANNELS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// item input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // oscillator_count[7:0], check_channel[9:8], zero fill
	input  logic [1:0]  s_tuser,   // func[1:0]
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // touched[0], scan_channel[2:1], zero fill
);

	ctdd_pkg::cfg_t cfg;
	ctdd_pkg::op_t  op_s1;
	ctdd_pkg::res_t res;
	ctdd_pkg::res_t res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           s2_ready;
	logic           step;

	// stage handshake
	assign s2_ready = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || s2_ready;
	assign step     = valid_s1 && s2_ready;

	ctdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1.func             <= s_tuser;
			op_s1.oscillator_count <= s_tdata[7:0];
			op_s1.check_channel    <= s_tdata[9:8];
		end
	end

	ctdd_engine #(
		.CHANNELS (CHANNELS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.op     (op_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.scan_channel, res_s2.touched};

	`CTDD_ASSERT_IMP(a_stall_full, clk, arst_n, !s_tready, (valid_s1 && valid_s2 && !m_tready))
	`CTDD_ASSERT_NXT(a_s1_held, clk, arst_n, (valid_s1 && !s2_ready), valid_s1)

endmodule

@@ test/tb_capacitive_touch_drop_detector_core.sv @@
module tb_capacitive_touch_drop_detector_core;
	import ctdd_pkg::*;

	localparam int NCH         = CHANNELS_DEFAULT;
	localparam int LONG_HOLD   = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 125;

	// selector value with no operation behind it
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] count;
		logic [1:0] channel;
	} sense_item_t;

	typedef struct packed {
		logic       touched;
		logic [1:0] scan;
	} answer_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [15:0] s_tdata  = '0;
	logic [1:0] s_tuser   = '0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;

	// shadow of the detector state and its registers
	logic [7:0] cur_cnt [NCH];
	logic [7:0] prev_cnt [NCH];
	logic [7:0] lock_tmr [NCH];
	logic [1:0] scan_ptr;
	logic [7:0] thr [NCH];
	logic [7:0] lock_reload;

	// items waiting to be sent and answers waiting to arrive
	sense_item_t sense_items [$];
	answer_t     answers [$];

	// generator view of the scan position and last captured counts
	int gen_scan;
	int gen_last [NCH];
	int gen_total;

	logic noise_on = 1'b1;
	int   hold_requests = 0;
	int   hold_served   = 0;
	int   hold_left     = 0;
	int   send_gap      = 0;
	int   sink_gap      = 0;
	int   idle_cycles   = 0;
	int   errors        = 0;
	int   items_taken   = 0;
	int   touches_seen  = 0;
	int   settings_run  = 1;

	capacitive_touch_drop_detector_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one item through the shadow detector
	function automatic answer_t detect_step(input sense_item_t it);
		answer_t a;
		int      ch;
		a.touched = 1'b0;
		ch = int'(it.channel);
		case (it.func)
			FUNC_CAPTURE: begin
				prev_cnt[scan_ptr] = cur_cnt[scan_ptr];
				cur_cnt[scan_ptr]  = it.count;
				scan_ptr = (int'(scan_ptr) == NCH - 1) ? 2'd0 : scan_ptr + 2'd1;
			end
			FUNC_TICK: begin
				for (int i = 0; i < NCH; i++)
					if (lock_tmr[i] != 8'd0)
						lock_tmr[i] = lock_tmr[i] - 8'd1;
			end
			FUNC_CHECK: begin
				// drop compared without wrap, only once the lockout has run out
				if (ch < NCH) begin
					if (int'(prev_cnt[ch]) > int'(cur_cnt[ch]) + int'(thr[ch]) &&
						lock_tmr[ch] == 8'd0) begin
						lock_tmr[ch] = lock_reload;
						a.touched = 1'b1;
					end
				end
			end
			default: ;
		endcase
		a.scan = scan_ptr;
		return a;
	endfunction

	// queue one item and keep the generator view in step
	task automatic push_item(input logic [1:0] func, input logic [7:0] count,
			input logic [1:0] channel);
		sense_item_t it;
		it.func    = func;
		it.count   = count;
		it.channel = channel;
		sense_items.push_back(it);
		gen_total++;
		if (func == FUNC_CAPTURE) begin
			gen_last[gen_scan] = int'(count);
			gen_scan = (gen_scan == NCH - 1) ? 0 : gen_scan + 1;
		end
	endtask

	// register writes, called just after a rising edge while idle
	task automatic apply_config(input logic [7:0] t0, input logic [7:0] t1,
			input logic [7:0] t2, input logic [7:0] lk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_THRESHOLD_CH0;
		cfg_data  <= t0;
		@(posedge clk);
		cfg_index <= REG_THRESHOLD_CH1;
		cfg_data  <= t1;
		@(posedge clk);
		cfg_index <= REG_THRESHOLD_CH2;
		cfg_data  <= t2;
		@(posedge clk);
		cfg_index <= REG_LOCKOUT;
		cfg_data  <= lk;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr[0]      = t0;
		thr[1]      = t1;
		thr[2]      = t2;
		lock_reload = lk;
		settings_run++;
	endtask

	// wait until every item is sent and answered
	task automatic settle();
		do
			@(negedge clk);
		while (sense_items.size() != 0 || s_tvalid || answers.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// capture rounds with chosen drops, then checks and ticks, with some noise
	task automatic gen_random(input int n);
		int target;
		int c;
		int v;
		int drop;
		target = gen_total + n;
		while (gen_total < target) begin
			if ($urandom_range(0, 9) < 2) begin
				push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					2'($urandom_range(0, 3)));
			end else begin
				repeat (NCH) begin
					c = gen_scan;
					case ($urandom_range(0, 3))
						0: v = $urandom_range(0, 255);
						1: begin
							// drop right at the threshold or just past it
							drop = int'(thr[c]) + $urandom_range(0, 2);
							v = (gen_last[c] >= drop) ? gen_last[c] - drop : 0;
						end
						2: begin
							v = gen_last[c] + $urandom_range(0, 3);
							if (v > 255)
								v = 255;
						end
						default: v = $urandom_range(160, 255);
					endcase
					push_item(FUNC_CAPTURE, 8'(v), 2'd0);
				end
				repeat ($urandom_range(1, 4))
					push_item(FUNC_CHECK, 8'($urandom_range(0, 255)),
						($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
				// now and then tick long enough to clear every lockout, if it fits the phase
				if ($urandom_range(0, 11) == 0 && gen_total + int'(lock_reload) + 1 <= target)
					repeat (int'(lock_reload) + $urandom_range(0, 1))
						push_item(FUNC_TICK, 8'($urandom_range(0, 255)),
							2'($urandom_range(0, 3)));
				else
					repeat ($urandom_range(0, 3))
						push_item(FUNC_TICK, 8'($urandom_range(0, 255)),
							2'($urandom_range(0, 3)));
			end
		end
	endtask

	// stimulus sequence
	initial begin
		logic [7:0] t0;
		logic [7:0] t1;
		logic [7:0] t2;
		logic [7:0] lk;
		for (int i = 0; i < NCH; i++) begin
			cur_cnt[i]  = 8'd0;
			prev_cnt[i] = 8'd0;
			lock_tmr[i] = 8'd0;
			thr[i]      = THRESHOLD_RESET;
			gen_last[i] = 0;
		end
		scan_ptr    = 2'd0;
		lock_reload = LOCKOUT_RESET;
		gen_scan    = 0;
		gen_total   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: fresh state, drop past and at the threshold, lockout
		@(negedge clk);
		push_item(FUNC_CHECK, 8'd0, 2'd0);
		push_item(FUNC_CAPTURE, 8'd255, 2'd0);
		push_item(FUNC_CAPTURE, 8'd255, 2'd0);
		push_item(FUNC_CAPTURE, 8'd0, 2'd0);
		push_item(FUNC_CAPTURE, 8'd234, 2'd0);
		push_item(FUNC_CAPTURE, 8'd235, 2'd0);
		push_item(FUNC_CAPTURE, 8'd255, 2'd0);
		push_item(FUNC_CHECK, 8'd0, 2'd0);
		push_item(FUNC_CHECK, 8'd0, 2'd0);
		push_item(FUNC_CHECK, 8'd0, 2'd1);
		push_item(FUNC_CHECK, 8'd0, 2'd2);
		push_item(FUNC_CHECK, 8'd255, 2'd3);
		push_item(FUNC_UNUSED, 8'd255, 2'd3);
		push_item(FUNC_TICK, 8'd0, 2'd0);
		push_item(FUNC_CAPTURE, 8'd0, 2'd0);
		push_item(FUNC_CHECK, 8'd0, 2'd0);
		settle();

		// extreme thresholds and no lockout
		apply_config(8'd0, 8'd255, 8'd1, 8'd0);
		@(negedge clk);
		push_item(FUNC_CAPTURE, 8'd0, 2'd0);
		push_item(FUNC_CAPTURE, 8'd0, 2'd0);
		push_item(FUNC_CAPTURE, 8'd1, 2'd0);
		push_item(FUNC_CHECK, 8'd0, 2'd1);
		push_item(FUNC_CHECK, 8'd0, 2'd2);
		push_item(FUNC_CHECK, 8'd0, 2'd2);
		push_item(FUNC_CHECK, 8'd0, 2'd0);
		push_item(FUNC_TICK, 8'd255, 2'd3);
		settle();

		// random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			t0 = 8'($urandom_range(0, 50));
			t1 = 8'($urandom_range(0, 50));
			t2 = 8'($urandom_range(0, 50));
			lk = 8'($urandom_range(0, 10));
			case (p)
				0: lk = 8'($urandom_range(1, 6));
				1: begin
					t0 = 8'd255;
					t1 = 8'd255;
					t2 = 8'd255;
					lk = 8'd255;
				end
				2: begin
					t0 = 8'd0;
					t1 = 8'd0;
					t2 = 8'd0;
					lk = 8'($urandom_range(0, 3));
				end
				3: begin
					t0 = 8'($urandom_range(0, 255));
					t1 = 8'($urandom_range(0, 255));
					t2 = 8'($urandom_range(0, 255));
					lk = 8'($urandom_range(0, 255));
				end
				4: lk = 8'd255;
				5: lk = 8'd1;
				default: ;
			endcase
			apply_config(t0, t1, t2, lk);
			if (p == 2)
				hold_requests <= hold_requests + 1;
			noise_on <= (p != PHASES - 1);
			@(negedge clk);
			gen_random(PHASE_ITEMS);
			settle();
		end

		$display("covered %0d items under %0d register settings, %0d touches reported",
			items_taken, settings_run, touches_seen);
		if (errors == 0)
			$display("tb_capacitive_touch_drop_detector_core: done, clean");
		else
			$display("tb_capacitive_touch_drop_detector_core: done, errors");
		$finish;
	end

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				answers.push_back(detect_step(sense_items[0]));
				sense_items.pop_front();
				items_taken++;
			end
			// an offered item stays put until taken
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (sense_items.size() != 0 && noise_on && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else if (sense_items.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {6'd0, sense_items[0].channel, sense_items[0].count};
					s_tuser  <= sense_items[0].func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (m_tdata[0])
					touches_seen++;
				if (answers.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual touched=%0d scan=%0d",
						$time, m_tdata[0], m_tdata[2:1]);
				end else begin
					want = answers.pop_front();
					if (m_tdata[0] !== want.touched) begin
						errors++;
						$display("%0t: touched mismatch, expected %0d, actual %0d",
							$time, want.touched, m_tdata[0]);
					end
					if (m_tdata[2:1] !== want.scan) begin
						errors++;
						$display("%0t: scan_channel mismatch, expected %0d, actual %0d",
							$time, want.scan, m_tdata[2:1]);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				// long hold-off so the block backs up into its input
				hold_served = hold_requests;
				hold_left   = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (noise_on && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("tb_capacitive_touch_drop_detector_core: done, errors");
				$finish;
			end
		end
	end

endmodule
